// File: design/deq_pkg.sv
// Shared types and defaults for the double-ended queue with iterator.
// Operation codes, status codes and default sizes; no dependencies.
package deq_pkg;

  // Default sizes, handed to the top level parameters
  localparam int DEPTH_DEF      = 256;
  localparam int DATA_WIDTH_DEF = 16;

  // Operation field width and codes (codes six and seven do nothing)
  localparam int FUNC_WIDTH = 3;
  typedef enum logic [FUNC_WIDTH-1:0] {
    FN_PUSH_FRONT = 3'd0,
    FN_PUSH_BACK  = 3'd1,
    FN_POP_FRONT  = 3'd2,
    FN_POP_BACK   = 3'd3,
    FN_ITER_RESET = 3'd4,
    FN_ITER_NEXT  = 3'd5
  } func_t;

  // Result status
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

endpackage

// File: design/deq_if.sv
// Valid/ready channel interfaces for the deque: request and result.
// Depends on deq_pkg for the field widths and status type.
interface deq_in_if
  import deq_pkg::*;
#(
  parameter int DW = DATA_WIDTH_DEF
);
  logic                  valid;
  logic                  ready;
  logic [FUNC_WIDTH-1:0] func;
  logic [DW-1:0]         data_in;

  modport source (output valid, func, data_in, input ready);
  modport sink   (input valid, func, data_in, output ready);
endinterface

interface deq_out_if
  import deq_pkg::*;
#(
  parameter int DW = DATA_WIDTH_DEF,
  parameter int LW = $clog2(DEPTH_DEF + 1)
);
  logic          valid;
  logic          ready;
  logic [DW-1:0] data_out;
  logic          data_valid;
  logic [LW-1:0] length;
  status_t       status;

  modport source (output valid, data_out, data_valid, length, status, input ready);
  modport sink   (input valid, data_out, data_valid, length, status, output ready);
endinterface

// File: design/deq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// Read data holds when no read is issued; no dependencies.
module deq_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/double_ended_queue_with_iterator.sv
// Bounded deque in a ring of DEPTH slots with a forward read iterator.
// A request is taken into the pending stage while its slot memory read is
// under way, and its result then moves on to the output register;
// sustained rate is one transaction per clock while the result side keeps
// up. A request is held off only while a result waits behind a stalled
// output register. Pointers and length live in flip-flops and need no
// clearing pass; slots are only read inside the live range. A push to a full
// deque is dropped with status full; a pop on an empty deque returns zero
// with status empty; the iterator reports empty once past the tail or once
// its slot has been popped.
// Depends on deq_pkg, deq_if and deq_ram.
module double_ended_queue_with_iterator
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEPTH_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  deq_in_if.sink    in_ch,
  deq_out_if.source out_ch
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;

  // Ring pointers and iterator
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] iter_r, iter_nxt;
  logic          iter_end_r, iter_end_nxt;

  // Pending result (memory read in flight)
  logic          pend_r;
  logic          pend_rd_r, pend_rd_nxt;
  logic [CW-1:0] pend_len_r;
  status_t       pend_st_r, pend_st_nxt;

  // Output register
  logic                  out_valid_r;
  logic [DATA_WIDTH-1:0] out_data_r;
  logic                  out_dv_r;
  logic [CW-1:0]         out_len_r;
  status_t               out_st_r;

  // Memory port signals
  logic                  we, re;
  logic [AW-1:0]         waddr, raddr;
  logic [DATA_WIDTH-1:0] rdata;

  logic          acc, can_move;
  logic [AW-1:0] head_dec, head_inc, iter_inc, tail_idx, last_idx;
  logic [CW-1:0] offset;
  logic          full, empty;

  // Modular add of two ring values whose sum is below twice DEPTH
  function automatic logic [AW-1:0] wrap_sum(input logic [SW-1:0] s);
    logic [SW-1:0] d;
    d = s - SW'(DEPTH);
    return (s >= SW'(DEPTH)) ? d[AW-1:0] : s[AW-1:0];
  endfunction

  deq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (in_ch.data_in),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Handshake
  assign can_move    = pend_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !pend_r || can_move;
  assign acc         = in_ch.valid && in_ch.ready;

  // Ring index arithmetic
  assign full     = (count_r >= CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + AW'(1);
  assign iter_inc = (iter_r == AW'(DEPTH - 1)) ? '0 : iter_r + AW'(1);
  assign tail_idx = wrap_sum(SW'(head_r) + SW'(count_r));
  assign last_idx = wrap_sum(SW'(head_r) + SW'(count_r - CW'(1)));
  assign offset   = (iter_r >= head_r) ? CW'(iter_r - head_r)
                                       : CW'(SW'(iter_r) + SW'(DEPTH) - SW'(head_r));

  // Operation decode, pointer update and memory access
  always_comb begin
    head_nxt     = head_r;
    count_nxt    = count_r;
    iter_nxt     = iter_r;
    iter_end_nxt = iter_end_r;
    pend_rd_nxt  = 1'b0;
    pend_st_nxt  = ST_OK;
    we           = 1'b0;
    re           = 1'b0;
    waddr        = tail_idx;
    raddr        = head_r;
    unique case (in_ch.func)
      FN_PUSH_FRONT: begin
        if (full) begin
          pend_st_nxt = ST_FULL;
        end else begin
          we        = acc;
          waddr     = head_dec;
          head_nxt  = head_dec;
          count_nxt = count_r + CW'(1);
        end
      end
      FN_PUSH_BACK: begin
        if (full) begin
          pend_st_nxt = ST_FULL;
        end else begin
          we        = acc;
          waddr     = tail_idx;
          count_nxt = count_r + CW'(1);
        end
      end
      FN_POP_FRONT: begin
        if (empty) begin
          pend_st_nxt = ST_EMPTY;
        end else begin
          re          = acc;
          raddr       = head_r;
          pend_rd_nxt = 1'b1;
          head_nxt    = head_inc;
          count_nxt   = count_r - CW'(1);
        end
      end
      FN_POP_BACK: begin
        if (empty) begin
          pend_st_nxt = ST_EMPTY;
        end else begin
          re          = acc;
          raddr       = last_idx;
          pend_rd_nxt = 1'b1;
          count_nxt   = count_r - CW'(1);
        end
      end
      FN_ITER_RESET: begin
        iter_nxt     = head_r;
        iter_end_nxt = empty;
      end
      FN_ITER_NEXT: begin
        if (iter_end_r || offset >= count_r) begin
          iter_end_nxt = 1'b1;
          pend_st_nxt  = ST_EMPTY;
        end else begin
          re           = acc;
          raddr        = iter_r;
          pend_rd_nxt  = 1'b1;
          iter_nxt     = iter_inc;
          iter_end_nxt = (offset + CW'(1) >= count_r);
        end
      end
      default: begin
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      count_r    <= '0;
      iter_r     <= '0;
      iter_end_r <= 1'b1;
    end else if (acc) begin
      head_r     <= head_nxt;
      count_r    <= count_nxt;
      iter_r     <= iter_nxt;
      iter_end_r <= iter_end_nxt;
    end
  end

  // Pending stage: result waits here for the memory read data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= 1'b0;
    end else if (acc) begin
      pend_r <= 1'b1;
    end else if (can_move) begin
      pend_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      pend_rd_r  <= pend_rd_nxt;
      pend_st_r  <= pend_st_nxt;
      pend_len_r <= count_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (can_move) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (can_move) begin
      out_data_r <= pend_rd_r ? rdata : '0;
      out_dv_r   <= pend_rd_r;
      out_len_r  <= pend_len_r;
      out_st_r   <= pend_st_r;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.data_out   = out_data_r;
  assign out_ch.data_valid = out_dv_r;
  assign out_ch.length     = out_len_r;
  assign out_ch.status     = out_st_r;

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("deque length exceeds depth");

  a_valid_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_dv_r |-> out_st_r == ST_OK)
    else $error("element returned with a bad status");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_dv_r |-> out_data_r == '0)
    else $error("nonzero data without an element");

  // Read data only matters for a pending result that read a slot
  a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r && !can_move |=> pend_r && $stable(pend_len_r) &&
                            (!pend_rd_r || $stable(rdata)))
    else $error("pending result lost while output stalled");

endmodule

// File: tb/double_ended_queue_with_iterator_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the ring-store deque with forward iterator.
// Depends on deq_pkg, deq_if and the double_ended_queue_with_iterator RTL.
module double_ended_queue_with_iterator_tb;
  import deq_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int DW    = DATA_WIDTH_DEF;
  localparam int LW    = $clog2(DEPTH_DEF + 1);

  // Undefined operation codes; the block treats them as no-ops
  localparam logic [FUNC_WIDTH-1:0] FN_NOP_6 = 3'd6;
  localparam logic [FUNC_WIDTH-1:0] FN_NOP_7 = 3'd7;

  localparam int RANDOM_OPS = 1850;
  localparam int CALM_TAIL  = 150;
  localparam int CYCLE_CAP  = 400000;

  typedef enum logic [1:0] {
    LOAD_GROW,
    LOAD_SHRINK,
    LOAD_MIXED
  } load_mode_t;

  typedef struct {
    logic [DW-1:0] data;
    logic          dv;
    logic [LW-1:0] len;
    status_t       st;
  } deq_result_t;

  // Shadow copy of the deque; predicts each result and checks it in order
  class deque_shadow;
    logic [DW-1:0] ring [DEPTH];
    int unsigned   head;
    int unsigned   fill;
    int unsigned   iter_pos;
    bit            iter_done;
    deq_result_t   expected_q [$];
    int unsigned   mismatches;

    function new();
      head       = 0;
      fill       = 0;
      iter_pos   = 0;
      iter_done  = 1'b1;
      mismatches = 0;
    endfunction

    function void note_request(logic [FUNC_WIDTH-1:0] fn, logic [DW-1:0] din);
      deq_result_t r;
      int unsigned ofs;
      r.data = '0;
      r.dv   = 1'b0;
      r.st   = ST_OK;
      case (fn)
        FN_PUSH_FRONT, FN_PUSH_BACK: begin
          if (fill >= DEPTH) begin
            r.st = ST_FULL;
          end else if (fn == FN_PUSH_FRONT) begin
            head = (head + DEPTH - 1) % DEPTH;
            ring[head] = din;
            fill++;
          end else begin
            ring[(head + fill) % DEPTH] = din;
            fill++;
          end
        end
        FN_POP_FRONT: begin
          if (fill == 0) begin
            r.st = ST_EMPTY;
          end else begin
            r.data = ring[head];
            r.dv   = 1'b1;
            head   = (head + 1) % DEPTH;
            fill--;
          end
        end
        FN_POP_BACK: begin
          if (fill == 0) begin
            r.st = ST_EMPTY;
          end else begin
            r.data = ring[(head + fill - 1) % DEPTH];
            r.dv   = 1'b1;
            fill--;
          end
        end
        FN_ITER_RESET: begin
          iter_pos  = head;
          iter_done = (fill == 0);
        end
        FN_ITER_NEXT: begin
          // offset from head; at or past count means the slot was popped
          ofs = (iter_pos + DEPTH - head) % DEPTH;
          if (iter_done || ofs >= fill) begin
            iter_done = 1'b1;
            r.st      = ST_EMPTY;
          end else begin
            r.data   = ring[iter_pos];
            r.dv     = 1'b1;
            iter_pos = (iter_pos + 1) % DEPTH;
            if (ofs + 1 >= fill) iter_done = 1'b1;
          end
        end
        default: ;
      endcase
      r.len = LW'(fill);
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [DW-1:0] data, logic dv, logic [LW-1:0] len,
                               status_t st);
      deq_result_t r;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding: data_out %h", data);
        mismatches++;
        return;
      end
      r = expected_q.pop_front();
      if (data !== r.data) begin
        $error("data_out: expected %h, got %h", r.data, data);
        mismatches++;
      end
      if (dv !== r.dv) begin
        $error("data_valid: expected %b, got %b", r.dv, dv);
        mismatches++;
      end
      if (len !== r.len) begin
        $error("length: expected %0d, got %0d", r.len, len);
        mismatches++;
      end
      if (st !== r.st) begin
        $error("status: expected %0d, got %0d", r.st, st);
        mismatches++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic clk;
  logic rst_n;
  bit   calm;
  int   gap_pct;
  int   stall_pct;
  int unsigned cycles;

  deque_shadow shadow;

  deq_in_if  #(.DW(DW))          in_ch ();
  deq_out_if #(.DW(DW), .LW(LW)) out_ch ();

  double_ended_queue_with_iterator #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DW)
  ) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Present one request and hold it until the block takes it
  task automatic issue_op(logic [FUNC_WIDTH-1:0] fn, logic [DW-1:0] din);
    in_ch.valid   <= 1'b1;
    in_ch.func    <= fn;
    in_ch.data_in <= din;
    do @(negedge clk); while (!in_ch.ready);
    @(posedge clk);
  endtask

  // Random idle burst on the request side
  task automatic source_gap();
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
  endtask

  // Operation mix for the current load phase
  function automatic logic [FUNC_WIDTH-1:0] pick_func(load_mode_t mode);
    int push_w;
    int pop_w;
    int roll;
    case (mode)
      LOAD_GROW:   begin push_w = 70; pop_w = 10; end
      LOAD_SHRINK: begin push_w = 10; pop_w = 70; end
      default:     begin push_w = 35; pop_w = 30; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < push_w)
      return $urandom_range(0, 1) ? FN_PUSH_FRONT : FN_PUSH_BACK;
    if (roll < push_w + pop_w)
      return $urandom_range(0, 1) ? FN_POP_FRONT : FN_POP_BACK;
    if (roll < push_w + pop_w + 6)
      return FN_ITER_RESET;
    if (roll < 98)
      return FN_ITER_NEXT;
    return $urandom_range(0, 1) ? FN_NOP_6 : FN_NOP_7;
  endfunction

  // Request and result monitor; values are stable at the falling edge
  always @(negedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        shadow.note_request(in_ch.func, in_ch.data_in);
      if (out_ch.valid && out_ch.ready)
        shadow.check_result(out_ch.data_out, out_ch.data_valid, out_ch.length,
                            out_ch.status);
    end
  end

  // Result-side backpressure in bursts, at a stall rate that is changed at random
  initial begin
    int n;
    out_ch.ready <= 1'b1;
    stall_pct = 5;
    forever begin
      @(posedge clk);
      if (cycles % 128 == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 5;
          default: stall_pct = 20;
        endcase
      end
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        n = $urandom_range(1, 16);
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Main stimulus
  initial begin
    load_mode_t mode;
    logic [FUNC_WIDTH-1:0] fn;
    shadow  = new();
    cycles  = 0;
    calm    = 1'b0;
    gap_pct = 25;
    in_ch.valid   <= 1'b0;
    in_ch.func    <= FN_NOP_6;
    in_ch.data_in <= '0;
    rst_n <= 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: empty-deque corners, wrap of the head, extremes of data,
    // iterator through the tail and after its slot is popped at either end
    issue_op(FN_POP_FRONT, 16'h1234);  source_gap();
    issue_op(FN_POP_BACK, 16'h4321);   source_gap();
    issue_op(FN_ITER_NEXT, '0);        source_gap();
    issue_op(FN_ITER_RESET, '0);       source_gap();
    issue_op(FN_ITER_NEXT, '0);        source_gap();
    issue_op(FN_NOP_6, 16'hFFFF);      source_gap();
    issue_op(FN_PUSH_FRONT, 16'hFFFF); source_gap();
    issue_op(FN_PUSH_BACK, 16'h0000);  source_gap();
    issue_op(FN_PUSH_BACK, 16'hA5A5);  source_gap();
    issue_op(FN_PUSH_FRONT, 16'h5A5A); source_gap();
    issue_op(FN_NOP_7, 16'h0000);      source_gap();
    issue_op(FN_ITER_RESET, '0);       source_gap();
    issue_op(FN_ITER_NEXT, '0);        source_gap();
    issue_op(FN_ITER_NEXT, '0);        source_gap();
    issue_op(FN_POP_FRONT, '0);        source_gap();
    issue_op(FN_POP_FRONT, '0);        source_gap();
    issue_op(FN_ITER_NEXT, '0);        source_gap();
    issue_op(FN_POP_BACK, '0);         source_gap();
    issue_op(FN_ITER_NEXT, '0);        source_gap();
    issue_op(FN_ITER_RESET, '0);       source_gap();
    issue_op(FN_ITER_NEXT, '0);        source_gap();
    issue_op(FN_ITER_NEXT, '0);        source_gap();
    issue_op(FN_ITER_RESET, '0);       source_gap();
    issue_op(FN_POP_FRONT, '0);        source_gap();
    issue_op(FN_ITER_NEXT, '0);        source_gap();

    // Random: swing between full and empty so both limits are hit repeatedly
    mode = LOAD_GROW;
    for (int i = 0; i < RANDOM_OPS; i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: gap_pct = 0;
          1: gap_pct = 10;
          default: gap_pct = 30;
        endcase
      end
      calm = (i >= RANDOM_OPS - CALM_TAIL);
      case (mode)
        LOAD_GROW:
          if (shadow.fill == DEPTH && $urandom_range(0, 7) == 0) mode = LOAD_SHRINK;
        LOAD_SHRINK:
          if (shadow.fill == 0 && $urandom_range(0, 3) == 0)
            mode = $urandom_range(0, 1) ? LOAD_MIXED : LOAD_GROW;
        default:
          if ($urandom_range(0, 149) == 0) mode = LOAD_GROW;
      endcase
      fn = pick_func(mode);
      issue_op(fn, DW'($urandom()));
      source_gap();
    end

    // Drain outstanding results, then allow the output stage to settle
    in_ch.valid <= 1'b0;
    while (shadow.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (shadow.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
